FILE: hdl/tfs_pkg.sv
// Package for the timed serial frame sender.
// Holds register widths, reset values, register indexes, phase codes and shared types.
// No dependencies.
`default_nettype none

package tfs_pkg;

   // Register widths.
   localparam int TickStepW   = 16;
   localparam int BitPeriodW  = 24;
   localparam int IdlePeriodW = 26;
   localparam int ValueBytesW = 64;
   localparam int ValueCountW = 4;
   localparam int ElapsedW    = 32;
   localparam int BitCountW   = 4;
   localparam int BytePtrW    = 3;
   localparam int PhaseW      = 3;

   // Configuration port geometry.
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 64;

   // Stream payload widths.
   localparam int ReqDataW = 8;
   localparam int RspDataW = 8;

   // Parameter defaults.
   localparam int DefMaxBytes = 8;
   localparam int DefDataBits = 8;

   // Register reset values.
   localparam logic [TickStepW-1:0]   TickStepReset   = 16'd1707;
   localparam logic [BitPeriodW-1:0]  BitPeriodReset  = 24'd250000;
   localparam logic [IdlePeriodW-1:0] IdlePeriodReset = 26'd2000000;
   localparam logic [ValueBytesW-1:0] ValueBytesReset = 64'd197890;
   localparam logic [ValueCountW-1:0] ValueCountReset = 4'd3;

   // Register indexes on the configuration port.
   localparam logic [CsrAddrW-1:0] REG_TICK_STEP   = 3'd0;
   localparam logic [CsrAddrW-1:0] REG_BIT_PERIOD  = 3'd1;
   localparam logic [CsrAddrW-1:0] REG_IDLE_PERIOD = 3'd2;
   localparam logic [CsrAddrW-1:0] REG_VALUE_BYTES = 3'd3;
   localparam logic [CsrAddrW-1:0] REG_VALUE_COUNT = 3'd4;

   // Phase codes as reported on the result channel.
   localparam logic [PhaseW-1:0] PH_IDLE  = 3'd0;
   localparam logic [PhaseW-1:0] PH_START = 3'd1;
   localparam logic [PhaseW-1:0] PH_DATA  = 3'd2;
   localparam logic [PhaseW-1:0] PH_STOP  = 3'd3;
   localparam logic [PhaseW-1:0] PH_DONE  = 3'd4;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_DATA  = 5'b00100,
      ST_STOP  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // Configuration register set.
   typedef struct packed {
      logic [TickStepW-1:0]   tick_step_us;
      logic [BitPeriodW-1:0]  bit_period_us;
      logic [IdlePeriodW-1:0] idle_period_us;
      logic [ValueBytesW-1:0] value_bytes;
      logic [ValueCountW-1:0] value_count;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic              line_level;
      logic [PhaseW-1:0] phase;
      logic              done_res;
   } result_type;

endpackage

`default_nettype wire

FILE: hdl/tfs_core.sv
// Sequencer of the timed serial frame sender: elapsed-time counter and frame state.
// Works out the state after one tick and presents it as the result of that transfer.
// Depends on tfs_pkg.
`default_nettype none

module tfs_core
   import tfs_pkg::*;
#(
   parameter int MAX_BYTES = DefMaxBytes,
   parameter int DATA_BITS = DefDataBits
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       step_en,   // an input transfer takes place
   input  wire logic       advance,   // the transfer carries a timer tick
   output      result_type result     // state after this transfer
);

   logic [ElapsedW-1:0]  elapsed_ff, elapsed_in;
   state_type            state_ff, state_in;
   logic [BitCountW-1:0] bit_cnt_ff, bit_cnt_in;
   logic [BytePtrW-1:0]  byte_ptr_ff, byte_ptr_in;
   logic                 line_ff, line_in;

   logic [ElapsedW:0]      sum;
   logic [ElapsedW-1:0]    elapsed_sat;
   logic [ElapsedW-1:0]    period;
   logic                   period_hit;
   logic [ValueCountW-1:0] eff_count;
   logic [ValueCountW-1:0] next_ptr;
   logic [BitCountW-1:0]   bit_cnt_inc;
   logic                   live;

   // Saturating elapsed-time sum and the period of the current phase.
   always_comb begin
      sum         = {1'b0, elapsed_ff} + {{(ElapsedW+1-TickStepW){1'b0}}, cfg.tick_step_us};
      elapsed_sat = sum[ElapsedW] ? {ElapsedW{1'b1}} : sum[ElapsedW-1:0];
      if (state_ff == ST_IDLE) begin
         period = {{(ElapsedW-IdlePeriodW){1'b0}}, cfg.idle_period_us};
      end else begin
         period = {{(ElapsedW-BitPeriodW){1'b0}}, cfg.bit_period_us};
      end
      period_hit = (elapsed_sat >= period);
      live       = step_en && advance && (state_ff != ST_DONE);
   end

   // Byte count clamped to one up to the table size.
   always_comb begin
      if (cfg.value_count == '0) begin
         eff_count = ValueCountW'(1);
      end else if (cfg.value_count > ValueCountW'(MAX_BYTES)) begin
         eff_count = ValueCountW'(MAX_BYTES);
      end else begin
         eff_count = cfg.value_count;
      end
      next_ptr    = {1'b0, byte_ptr_ff} + ValueCountW'(1);
      bit_cnt_inc = bit_cnt_ff + BitCountW'(1);
   end

   // Next state of the frame sequencer.
   always_comb begin
      elapsed_in  = elapsed_ff;
      state_in    = state_ff;
      bit_cnt_in  = bit_cnt_ff;
      byte_ptr_in = byte_ptr_ff;
      line_in     = line_ff;
      if (live) begin
         if (!period_hit) begin
            elapsed_in = elapsed_sat;
         end else begin
            elapsed_in = '0;
            unique case (state_ff)
               ST_IDLE: begin
                  state_in = ST_START;
                  line_in  = 1'b0;
               end
               ST_START: begin
                  state_in   = ST_DATA;
                  bit_cnt_in = '0;
                  line_in    = cfg.value_bytes[{byte_ptr_ff, 3'd0}];
               end
               ST_DATA: begin
                  if (bit_cnt_inc < BitCountW'(DATA_BITS)) begin
                     bit_cnt_in = bit_cnt_inc;
                     line_in    = cfg.value_bytes[{byte_ptr_ff, bit_cnt_inc[2:0]}];
                  end else begin
                     bit_cnt_in = '0;
                     state_in   = ST_STOP;
                     line_in    = 1'b1;
                  end
               end
               ST_STOP: begin
                  if (next_ptr < eff_count) begin
                     byte_ptr_in = next_ptr[BytePtrW-1:0];
                     state_in    = ST_START;
                     line_in     = 1'b0;
                  end else begin
                     state_in = ST_DONE;
                     line_in  = 1'b1;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff  <= '0;
         state_ff    <= ST_IDLE;
         bit_cnt_ff  <= '0;
         byte_ptr_ff <= '0;
         line_ff     <= 1'b1;
      end else begin
         elapsed_ff  <= elapsed_in;
         state_ff    <= state_in;
         bit_cnt_ff  <= bit_cnt_in;
         byte_ptr_ff <= byte_ptr_in;
         line_ff     <= line_in;
      end
   end

   // Result of the transfer, taken from the updated state.
   always_comb begin
      result.done_res   = (state_in == ST_DONE);
      result.line_level = result.done_res ? 1'b1 : line_in;
      unique case (state_in)
         ST_IDLE:  result.phase = PH_IDLE;
         ST_START: result.phase = PH_START;
         ST_DATA:  result.phase = PH_DATA;
         ST_STOP:  result.phase = PH_STOP;
         default:  result.phase = PH_DONE;
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/timed_serial_frame_sender.sv
// Top level of the timed serial frame sender: configuration registers and result register.
// Depends on tfs_pkg and tfs_core.
//
// Usage. Each transfer on the req_ stream is one step of a timer; with bit 0 of
// req_tdata set, tick_step_us microseconds pass, otherwise no time passes. The
// block holds the serial line high for idle_period_us, then sends each byte of
// value_bytes (byte zero first, value_count bytes clamped to 1..MAX_BYTES) as a low start bit, the
// data bits least significant first and a high stop bit, each bit_period_us long.
// After the last stop bit it stays finished, line high, until reset.
// Every req_ transfer yields exactly one rsp_ transfer carrying the line level,
// phase and done flag after that step.
// The result is registered and is on rsp_ in the cycle after the req_ transfer.
// Throughput: one item per cycle; the result register is refilled in the same
// cycle that its content is taken, so req_tready falls only while a result
// waits and rsp_tready is low.
// Reset (synchronous, active high) loads the register reset values, returns to
// the idle phase with the line high and empties the result register.
// Configuration is written on csr_ with no handshake; indexes 5 to 7 are ignored.
`default_nettype none

module timed_serial_frame_sender
   import tfs_pkg::*;
#(
   parameter int MAX_BYTES = DefMaxBytes,
   parameter int DATA_BITS = DefDataBits
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Input stream.
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,   // [0] advance, [7:1] zero
   // Result stream.
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   output      logic [RspDataW-1:0] rsp_tdata,   // [0] line_level, [3:1] phase, [4] done_res
   // Configuration writes.
   input  wire logic                csr_we,
   input  wire logic [CsrAddrW-1:0] csr_addr,
   input  wire logic [CsrDataW-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       req_fire;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_step_us   <= TickStepReset;
         cfg_ff.bit_period_us  <= BitPeriodReset;
         cfg_ff.idle_period_us <= IdlePeriodReset;
         cfg_ff.value_bytes    <= ValueBytesReset;
         cfg_ff.value_count    <= ValueCountReset;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_TICK_STEP:   cfg_ff.tick_step_us   <= csr_wdata[TickStepW-1:0];
            REG_BIT_PERIOD:  cfg_ff.bit_period_us  <= csr_wdata[BitPeriodW-1:0];
            REG_IDLE_PERIOD: cfg_ff.idle_period_us <= csr_wdata[IdlePeriodW-1:0];
            REG_VALUE_BYTES: cfg_ff.value_bytes    <= csr_wdata[ValueBytesW-1:0];
            REG_VALUE_COUNT: cfg_ff.value_count    <= csr_wdata[ValueCountW-1:0];
            default: ;
         endcase
      end
   end

   // Accept a new item whenever the result register is empty or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   tfs_core #(
      .MAX_BYTES (MAX_BYTES),
      .DATA_BITS (DATA_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step_en (req_fire),
      .advance (req_tdata[0]),
      .result  (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.done_res, rsp_ff.phase, rsp_ff.line_level};

endmodule

`default_nettype wire

FILE: verif/timed_serial_frame_sender_test.sv
// Self-checking testbench for timed_serial_frame_sender: timer ticks in, line states out.
// Depends on tfs_pkg and the timed_serial_frame_sender RTL; a class predicts each line state.
// Stimulus is a short directed opening and then randomised timing set-ups with bursty traffic.
module timed_serial_frame_sender_test
   import tfs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned MaxReported = 10;

   // Predicts the serial line for every tick and checks the returned line states.
   class serial_line_checker;
      logic [TickStepW-1:0]   tick_step;
      logic [BitPeriodW-1:0]  bit_period;
      logic [IdlePeriodW-1:0] idle_period;
      logic [ValueBytesW-1:0] value_bytes;
      logic [ValueCountW-1:0] value_count;

      logic [ElapsedW-1:0]  elapsed;
      logic [PhaseW-1:0]    phase;
      logic [BitCountW-1:0] bit_idx;
      logic [BytePtrW-1:0]  byte_idx;
      logic                 line;

      result_type  line_states_due[$];
      int unsigned mismatches;

      function new();
         tick_step   = TickStepReset;
         bit_period  = BitPeriodReset;
         idle_period = IdlePeriodReset;
         value_bytes = ValueBytesReset;
         value_count = ValueCountReset;
         elapsed     = '0;
         phase       = PH_IDLE;
         bit_idx     = '0;
         byte_idx    = '0;
         line        = 1'b1;
         mismatches  = 0;
      endfunction

      // Register writes take effect at once; indexes past the list change nothing.
      function void set_reg(logic [CsrAddrW-1:0] idx, logic [CsrDataW-1:0] val);
         case (idx)
            REG_TICK_STEP:   tick_step   = val[TickStepW-1:0];
            REG_BIT_PERIOD:  bit_period  = val[BitPeriodW-1:0];
            REG_IDLE_PERIOD: idle_period = val[IdlePeriodW-1:0];
            REG_VALUE_BYTES: value_bytes = val;
            REG_VALUE_COUNT: value_count = val[ValueCountW-1:0];
            default: ;
         endcase
      endfunction

      // Advances the frame by one accepted tick and queues the resulting line state.
      function void note_tick(logic advance);
         logic [ElapsedW:0]   sum;
         logic [ElapsedW-1:0] period;
         int unsigned         bytes_to_send;
         result_type          due;
         if (advance && phase < PH_DONE) begin
            // Elapsed time saturates rather than wrapping.
            sum = {1'b0, elapsed} + tick_step;
            elapsed = sum[ElapsedW] ? '1 : sum[ElapsedW-1:0];
            period = (phase == PH_IDLE) ? ElapsedW'(idle_period) : ElapsedW'(bit_period);
            if (elapsed >= period) begin
               elapsed = '0;
               case (phase)
                  PH_IDLE: begin
                     phase = PH_START;
                     line = 1'b0;
                  end
                  PH_START: begin
                     phase = PH_DATA;
                     bit_idx = '0;
                     line = value_bytes[byte_idx * 8];
                  end
                  PH_DATA: begin
                     bit_idx = bit_idx + 1'b1;
                     if (bit_idx < DefDataBits) begin
                        line = value_bytes[byte_idx * 8 + bit_idx];
                     end else begin
                        bit_idx = '0;
                        phase = PH_STOP;
                        line = 1'b1;
                     end
                  end
                  default: begin
                     // A count of zero sends one byte, a count past the table sends all of it.
                     bytes_to_send = value_count;
                     if (bytes_to_send == 0) bytes_to_send = 1;
                     if (bytes_to_send > DefMaxBytes) bytes_to_send = DefMaxBytes;
                     if (byte_idx + 1 < bytes_to_send) begin
                        byte_idx = byte_idx + 1'b1;
                        phase = PH_START;
                        line = 1'b0;
                     end else begin
                        phase = PH_DONE;
                        line = 1'b1;
                     end
                  end
               endcase
            end
         end
         due.done_res   = (phase >= PH_DONE);
         due.line_level = due.done_res ? 1'b1 : line;
         due.phase      = due.done_res ? PH_DONE : phase;
         line_states_due.push_back(due);
      endfunction

      // Compares one result transfer with the oldest queued line state.
      function void check_result(logic [RspDataW-1:0] got);
         result_type due;
         if (line_states_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display("Unexpected result transfer, tdata %b", got);
            return;
         end
         due = line_states_due.pop_front();
         if (got[0] !== due.line_level || got[3:1] !== due.phase ||
             got[4] !== due.done_res || got[RspDataW-1:5] !== '0) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display("Line state mismatch: expected line %b phase %0d done %b, got tdata %b",
                        due.line_level, due.phase, due.done_res, got);
         end
      endfunction

      function int unsigned pending();
         return line_states_due.size();
      endfunction

      function int unsigned failures();
         return mismatches + line_states_due.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   wire                 req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   wire                 rsp_tvalid;
   logic                rsp_tready = 1'b0;
   wire [RspDataW-1:0]  rsp_tdata;
   logic                csr_we = 1'b0;
   logic [CsrAddrW-1:0] csr_addr = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   serial_line_checker board;
   int unsigned        cycles = 0;
   int unsigned        stall_mode = 0;
   int unsigned        stall_left = 0;

   timed_serial_frame_sender i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // The receiver alternates between always ready, half ready and mostly stalled stretches.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(20, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Both channels are observed at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_tick(req_tdata[0]);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      end
   end

   // Offers one tick and holds it until the transfer completes.
   task automatic send_tick(input logic advance);
      req_tdata <= {{(ReqDataW-1){1'b0}}, advance};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int unsigned cycles_off);
      req_tvalid <= 1'b0;
      repeat (cycles_off) @(negedge clock);
   endtask

   // Stops sending until every queued line state has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
   endtask

   // Writes all five registers, then one index past the list that must change nothing.
   task automatic write_config(input logic [TickStepW-1:0] tick,
                               input logic [BitPeriodW-1:0] bit_len,
                               input logic [IdlePeriodW-1:0] idle_len,
                               input logic [ValueBytesW-1:0] bytes,
                               input logic [ValueCountW-1:0] count_val);
      logic [CsrAddrW-1:0] addrs [5];
      logic [CsrDataW-1:0] vals [5];
      logic [CsrAddrW-1:0] spare_addr;
      logic [CsrDataW-1:0] spare_data;
      addrs = '{REG_TICK_STEP, REG_BIT_PERIOD, REG_IDLE_PERIOD, REG_VALUE_BYTES, REG_VALUE_COUNT};
      vals = '{CsrDataW'(tick), CsrDataW'(bit_len), CsrDataW'(idle_len), CsrDataW'(bytes),
               CsrDataW'(count_val)};
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_addr <= addrs[i];
         csr_wdata <= vals[i];
         board.set_reg(addrs[i], vals[i]);
         @(negedge clock);
      end
      spare_addr = REG_VALUE_COUNT + CsrAddrW'($urandom_range(1, 3));
      spare_data = {$urandom, $urandom};
      csr_addr <= spare_addr;
      csr_wdata <= spare_data;
      board.set_reg(spare_addr, spare_data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Bursts of ticks with random gaps and the odd pause until all results are back.
   task automatic run_ticks(input int unsigned items, input int unsigned advance_pct);
      int unsigned left;
      int unsigned burst;
      left = items;
      while (left != 0) begin
         burst = $urandom_range(1, 16);
         if (burst > left) burst = left;
         repeat (burst) send_tick($urandom_range(0, 99) < advance_pct);
         left -= burst;
         if ($urandom_range(0, 29) == 0) drain_results();
         else if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 6));
      end
      drain_results();
   endtask

   // Random timing where each bit lasts between one and max_ratio advancing ticks.
   task automatic random_phase(input int unsigned tick_min, input int unsigned tick_max,
                               input logic [ValueCountW-1:0] count_val,
                               input int unsigned max_ratio, input int unsigned items);
      int unsigned tick;
      int unsigned bit_len;
      tick = $urandom_range(tick_min, tick_max);
      bit_len = tick * $urandom_range(1, max_ratio) - $urandom_range(0, tick - 1);
      write_config(TickStepW'(tick), BitPeriodW'(bit_len), IdlePeriodW'($urandom),
                   {$urandom, $urandom}, count_val);
      run_ticks(items, 80);
   endtask

   initial begin
      board = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset timing: time moves, but the idle period is far from over.
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      drain_results();

      // Zero tick step with the longest periods and a full table: nothing may move.
      write_config('0, '1, '1, '1, 4'd15);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      drain_results();

      // Largest step with zero periods: each advancing tick ends the phase.
      write_config('1, '0, '0, {$urandom, $urandom}, 4'd8);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      drain_results();

      // Three ticks per bit with an all-zero table.
      write_config(16'd1, 24'd3, 26'd1, '0, 4'd8);
      repeat (7) send_tick(1'b1);
      drain_results();

      // Random timing with a byte count that covers the full table.
      random_phase(1, 16, 4'd8, 14, 95);
      random_phase(1, 2000, 4'd15, 14, 95);
      random_phase(65535, 65535, ValueCountW'($urandom_range(8, 15)), 14, 95);
      repeat (4) random_phase(1, 65535, ValueCountW'($urandom_range(8, 15)), 14, 95);

      // Count dropped to zero mid-frame: the current byte is the last, then finished for good.
      random_phase(1, 300, 4'd0, 3, 150);

      repeat (4) @(posedge clock);
      if (board.failures() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/tfs_pkg.sv
hdl/tfs_core.sv
hdl/timed_serial_frame_sender.sv
verif/timed_serial_frame_sender_test.sv
